// File: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants for the lfu cache table
// ----------------------------------------------------------------------------
package lfu_pkg;
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming beat
        logic scan;    // step the serial search by one entry
        logic commit;  // apply the update
        logic respond; // drive the result strobe
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } t_stat;
endpackage

// File: src/lfu_cache_table_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// lfu key-value table with lru tie-break, serial search over entries
// ----------------------------------------------------------------------------
//  channel | ports                               | handshake
//  input   | i_action i_key i_value              | i_start high, o_busy low
//  result  | o_hit o_read_value                  | o_done strobe, one cycle
//  config  | i_cfg_data                          | i_cfg_we
//
// an item passes through one load, ENTRIES scan steps through the entry
// store, one commit and one result step. reset is synchronous and clears
// valid marks and occupancy; no clearing pass. the result cannot be
// stalled; a new item is taken the cycle after the strobe.
module lfu_cache_table_top #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_action,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic               o_hit,
    output logic signed [31:0] o_read_value,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);
    lfu_pkg::t_cmd  cmd;
    lfu_pkg::t_stat stat;
    logic [4:0] r_capacity;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_capacity <= 5'd16;
        else if (i_cfg_we) r_capacity <= i_cfg_data;
    end

    lfu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .o_done(o_done), .o_cmd(cmd), .i_stat(stat)
    );

    lfu_datapath #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_capacity(r_capacity), .i_action(i_action), .i_key(i_key),
        .i_value(i_value), .o_hit(o_hit), .o_read_value(o_read_value)
    );
endmodule

// File: src/lfu_datapath.sv
// ----------------------------------------------------------------------------
// lfu_datapath
// entry storage, serial match and victim search, update logic
// ----------------------------------------------------------------------------
module lfu_datapath #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfu_pkg::t_cmd      i_cmd,
    output lfu_pkg::t_stat     o_stat,
    input  logic [4:0]         i_capacity,
    input  logic               i_action,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_hit,
    output logic signed [31:0] o_read_value
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic                  r_valid [ENTRIES];
    logic [31:0]           r_ekey  [ENTRIES];
    logic [31:0]           r_edata [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt   [ENTRIES];
    logic [IW-1:0]         r_age   [ENTRIES];
    logic [OW-1:0]         r_occ;

    logic        r_act;
    logic [31:0] r_key, r_val;
    logic [IW-1:0] r_idx;
    logic        r_hit;
    logic [IW-1:0] r_hidx;
    logic        r_hv;  // have victim
    logic [IW-1:0] r_vidx;
    logic        r_hf;  // have free slot
    logic [IW-1:0] r_fidx;
    logic [31:0] r_rd;

    // effective capacity
    logic [OW:0] cap_eff;
    always_comb begin
        if (i_capacity == 5'd0)
            cap_eff = (OW+1)'(1);
        else if (32'(i_capacity) > ENTRIES)
            cap_eff = (OW+1)'(ENTRIES);
        else
            cap_eff = (OW+1)'(i_capacity);
    end

    assign o_stat.scan_last = (32'(r_idx) == ENTRIES - 1);

    // serial scan element compare
    logic cur_match, cur_better;
    always_comb begin
        cur_match  = r_valid[r_idx] && (r_ekey[r_idx] == r_key);
        cur_better = r_valid[r_idx] && (!r_hv || r_cnt[r_idx] < r_cnt[r_vidx] ||
                     (r_cnt[r_idx] == r_cnt[r_vidx] && r_age[r_idx] > r_age[r_vidx]));
    end

    // update decisions
    logic          do_evict, do_ins;
    logic [IW-1:0] slot, tidx;
    logic [IW-1:0] tr, vr;
    always_comb begin
        do_evict = !r_hit && r_act == lfu_pkg::ACT_PUT && r_hv &&
                   ((OW+1)'(r_occ) >= cap_eff);
        do_ins   = !r_hit && r_act == lfu_pkg::ACT_PUT && (do_evict || r_hf);
        slot     = do_evict ? r_vidx : r_fidx;
        tidx     = r_hidx;
        tr       = r_age[r_hidx];
        vr       = r_age[r_vidx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) r_valid[i] <= 1'b0;
            r_occ <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_act <= i_action;
                r_key <= i_key;
                r_val <= i_value;
                r_idx <= '0;
                r_hit <= 1'b0;
                r_hv  <= 1'b0;
                r_hf  <= 1'b0;
                r_hidx <= '0;
                r_vidx <= '0;
                r_fidx <= '0;
            end
            if (i_cmd.scan) begin
                if (cur_match && !r_hit) begin
                    r_hit <= 1'b1;
                    r_hidx <= r_idx;
                end
                if (cur_better) begin
                    r_hv <= 1'b1;
                    r_vidx <= r_idx;
                end
                if (!r_valid[r_idx] && !r_hf) begin
                    r_hf <= 1'b1;
                    r_fidx <= r_idx;
                end
                if (!o_stat.scan_last) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.commit) begin
                r_rd <= (r_act == lfu_pkg::ACT_PUT) ? 32'd0 :
                        (r_hit ? r_edata[r_hidx] : lfu_pkg::MISS_VALUE);
                if (r_hit) begin
                    if (r_act == lfu_pkg::ACT_PUT) r_edata[r_hidx] <= r_val;
                    if (r_cnt[r_hidx] != CMAX)
                        r_cnt[r_hidx] <= r_cnt[r_hidx] + COUNT_BITS'(1);
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_valid[i] && IW'(i) != tidx && r_age[i] < tr)
                            r_age[i] <= r_age[i] + IW'(1);
                    r_age[r_hidx] <= '0;
                end else if (do_ins) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_valid[i] && IW'(i) != slot) begin
                            if (do_evict && r_age[i] > vr) r_age[i] <= r_age[i];
                            else r_age[i] <= r_age[i] + IW'(1);
                        end
                    r_valid[slot] <= 1'b1;
                    r_ekey[slot]  <= r_key;
                    r_edata[slot] <= r_val;
                    r_cnt[slot]   <= COUNT_BITS'(1);
                    r_age[slot]   <= '0;
                    if (!do_evict) r_occ <= r_occ + OW'(1);
                end
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_read_value = r_rd;
endmodule

// File: src/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer: load, scan all entries, commit, respond
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    output lfu_pkg::t_cmd  o_cmd,
    input  lfu_pkg::t_stat i_stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (i_stat.scan_last) n_state = S_COMMIT;
            S_COMMIT: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = (r_state == S_RESP);
    assign o_cmd.load     = (r_state == S_IDLE) && i_start;
    assign o_cmd.scan     = (r_state == S_SCAN);
    assign o_cmd.commit   = (r_state == S_COMMIT);
    assign o_cmd.respond  = (r_state == S_RESP);

    // command checks
    a_onecmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.scan, o_cmd.commit, o_cmd.respond}))
        else $error("overlapping commands");
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_done) else $error("no result after commit");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("not idle after result");
endmodule
